// ===== rtl/bhe_pkg.sv =====
// shared types and constants for the button hold event generator
package bhe_pkg;

    localparam int NUM_BUTTONS_DEF = 4;
    localparam int TIME_BITS_DEF   = 32;

    localparam int HOLD_MS_BITS   = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int NOW_BITS       = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SHORT_HOLD     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_HOLD      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_VERYLONG_HOLD  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SUPERLONG_HOLD = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLOW_REPEAT    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FAST_REPEAT    = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT_ENABLE  = 3'd6;

    localparam logic [HOLD_MS_BITS-1:0] SHORT_HOLD_RST     = 16'd1000;
    localparam logic [HOLD_MS_BITS-1:0] LONG_HOLD_RST      = 16'd3000;
    localparam logic [HOLD_MS_BITS-1:0] VERYLONG_HOLD_RST  = 16'd5000;
    localparam logic [HOLD_MS_BITS-1:0] SUPERLONG_HOLD_RST = 16'd15000;
    localparam logic [HOLD_MS_BITS-1:0] SLOW_REPEAT_RST    = 16'd125;
    localparam logic [HOLD_MS_BITS-1:0] FAST_REPEAT_RST    = 16'd20;
    localparam logic                    REPEAT_ENABLE_RST  = 1'b1;

    localparam logic OP_POLL = 1'b0;
    localparam logic OP_STOP = 1'b1;

    localparam logic [1:0] BTN_UP   = 2'd2;
    localparam logic [1:0] BTN_DOWN = 2'd3;

    localparam logic [2:0] KIND_RELEASE = 3'd0;
    localparam logic [2:0] KIND_PRESS   = 3'd1;

    localparam logic [2:0] LEVEL_NONE      = 3'd0;
    localparam logic [2:0] LEVEL_SHORT     = 3'd2;
    localparam logic [2:0] LEVEL_LONG      = 3'd3;
    localparam logic [2:0] LEVEL_VERYLONG  = 3'd4;
    localparam logic [2:0] LEVEL_SUPERLONG = 3'd5;
    localparam logic [2:0] LEVEL_STOPPED   = 3'd6;

    localparam int MAX_EVENTS  = 3;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0] button;
        logic [2:0] kind;
        logic [2:0] prior;
    } event_t;

    typedef struct packed {
        logic [1:0]                    count;
        event_t [MAX_EVENTS-1:0]       events;
    } bundle_t;

endpackage

// ===== rtl/bhe_front.sv =====
// front end: config registers, hold state and per-poll event classification
module bhe_front
    import bhe_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      operation,
    input  logic [1:0]                button,
    input  logic                      pressed,
    input  logic [NOW_BITS-1:0]       now_ms,
    output logic                      push,
    output bundle_t                   push_bundle,
    input  logic                      push_ready
);

    logic [HOLD_MS_BITS-1:0] short_hold_reg;
    logic [HOLD_MS_BITS-1:0] long_hold_reg;
    logic [HOLD_MS_BITS-1:0] verylong_hold_reg;
    logic [HOLD_MS_BITS-1:0] superlong_hold_reg;
    logic [HOLD_MS_BITS-1:0] slow_repeat_reg;
    logic [HOLD_MS_BITS-1:0] fast_repeat_reg;
    logic                    repeat_enable_reg;

    logic                 active_valid_reg,  active_valid_next;
    logic [1:0]           active_button_reg, active_button_next;
    logic [2:0]           hold_level_reg,    hold_level_next;
    logic [TIME_BITS-1:0] press_time_reg,    press_time_next;
    logic [TIME_BITS-1:0] repeat_time_reg,   repeat_time_next;

    logic                    accept;
    logic [TIME_BITS-1:0]    now_t;
    logic                    poll_ok;
    logic                    new_press;
    logic                    same_btn;
    logic                    held_go;
    logic                    release_go;
    logic [2:0]              base_level;
    logic [2:0]              new_level;
    logic [2:0]              after_level;
    logic [TIME_BITS-1:0]    held_ms;
    logic [TIME_BITS-1:0]    rep_diff;
    logic [HOLD_MS_BITS-1:0] rate;
    logic                    is_updown;
    logic                    level_go;
    logic                    rep_go;
    logic                    rel_emit;
    bundle_t                 bundle;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;

    assign now_t      = TIME_BITS'(now_ms);
    assign poll_ok    = (operation == OP_POLL) && (int'(button) < NUM_BUTTONS);
    assign new_press  = poll_ok && !active_valid_reg && pressed;
    assign same_btn   = active_valid_reg && (active_button_reg == button);
    assign held_go    = poll_ok && pressed && (new_press || same_btn);
    assign release_go = poll_ok && !pressed && same_btn;
    assign base_level = new_press ? LEVEL_NONE : hold_level_reg;
    assign held_ms    = new_press ? '0 : (now_t - press_time_reg);
    assign is_updown  = (button == BTN_UP) || (button == BTN_DOWN);

    always_comb
    begin
        new_level = LEVEL_NONE;
        if (held_ms >= TIME_BITS'(superlong_hold_reg) && base_level < LEVEL_SUPERLONG)
        begin
            new_level = LEVEL_SUPERLONG;
        end
        else if (held_ms >= TIME_BITS'(verylong_hold_reg) && base_level < LEVEL_VERYLONG)
        begin
            new_level = LEVEL_VERYLONG;
        end
        else if (held_ms >= TIME_BITS'(long_hold_reg) && base_level < LEVEL_LONG)
        begin
            new_level = LEVEL_LONG;
        end
        else if (held_ms >= TIME_BITS'(short_hold_reg) && base_level < LEVEL_SHORT)
        begin
            new_level = LEVEL_SHORT;
        end
    end

    assign level_go    = held_go && (new_level != LEVEL_NONE);
    assign after_level = level_go ? new_level : base_level;
    assign rep_diff    = (level_go && new_level == LEVEL_SHORT) ? '0
                                                                : (now_t - repeat_time_reg);
    assign rate        = (after_level >= LEVEL_LONG) ? fast_repeat_reg : slow_repeat_reg;
    assign rep_go      = held_go && is_updown && repeat_enable_reg
                         && (after_level >= LEVEL_SHORT) && (rep_diff >= TIME_BITS'(rate));
    assign rel_emit    = release_go && (hold_level_reg != LEVEL_STOPPED);

    // pack the events of this poll into consecutive slots
    always_comb
    begin
        logic [1:0] slot;
        slot   = 2'd0;
        bundle = '0;
        if (new_press)
        begin
            bundle.events[slot] = '{button: button, kind: KIND_PRESS, prior: LEVEL_NONE};
            slot = slot + 2'd1;
        end
        if (level_go)
        begin
            bundle.events[slot] = '{button: button, kind: new_level, prior: base_level};
            slot = slot + 2'd1;
        end
        if (rep_go)
        begin
            bundle.events[slot] = '{button: button, kind: KIND_PRESS, prior: after_level};
            slot = slot + 2'd1;
        end
        if (rel_emit)
        begin
            bundle.events[slot] = '{button: button, kind: KIND_RELEASE, prior: hold_level_reg};
            slot = slot + 2'd1;
        end
        bundle.count = slot;
    end

    assign push        = accept && (bundle.count != 2'd0);
    assign push_bundle = bundle;

    always_comb
    begin
        active_valid_next  = active_valid_reg;
        active_button_next = active_button_reg;
        hold_level_next    = hold_level_reg;
        press_time_next    = press_time_reg;
        repeat_time_next   = repeat_time_reg;
        if (accept)
        begin
            if (operation == OP_STOP)
            begin
                hold_level_next = LEVEL_STOPPED;
            end
            else
            begin
                if (new_press)
                begin
                    active_valid_next  = 1'b1;
                    active_button_next = button;
                    press_time_next    = now_t;
                    hold_level_next    = LEVEL_NONE;
                end
                if (level_go)
                begin
                    hold_level_next = new_level;
                    if (new_level == LEVEL_SHORT)
                    begin
                        repeat_time_next = now_t;
                    end
                end
                if (rep_go)
                begin
                    repeat_time_next = now_t;
                end
                if (release_go)
                begin
                    active_valid_next = 1'b0;
                    hold_level_next   = LEVEL_NONE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_valid_reg  <= 1'b0;
            active_button_reg <= 2'd0;
            hold_level_reg    <= LEVEL_NONE;
            press_time_reg    <= '0;
            repeat_time_reg   <= '0;
        end
        else
        begin
            active_valid_reg  <= active_valid_next;
            active_button_reg <= active_button_next;
            hold_level_reg    <= hold_level_next;
            press_time_reg    <= press_time_next;
            repeat_time_reg   <= repeat_time_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_hold_reg     <= SHORT_HOLD_RST;
            long_hold_reg      <= LONG_HOLD_RST;
            verylong_hold_reg  <= VERYLONG_HOLD_RST;
            superlong_hold_reg <= SUPERLONG_HOLD_RST;
            slow_repeat_reg    <= SLOW_REPEAT_RST;
            fast_repeat_reg    <= FAST_REPEAT_RST;
            repeat_enable_reg  <= REPEAT_ENABLE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SHORT_HOLD:     short_hold_reg     <= cfg_data;
                REG_LONG_HOLD:      long_hold_reg      <= cfg_data;
                REG_VERYLONG_HOLD:  verylong_hold_reg  <= cfg_data;
                REG_SUPERLONG_HOLD: superlong_hold_reg <= cfg_data;
                REG_SLOW_REPEAT:    slow_repeat_reg    <= cfg_data;
                REG_FAST_REPEAT:    fast_repeat_reg    <= cfg_data;
                REG_REPEAT_ENABLE:  repeat_enable_reg  <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        !active_valid_reg |-> (hold_level_reg == LEVEL_NONE || hold_level_reg == LEVEL_STOPPED))
        else $error("idle front holds a live hold level");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && operation == OP_STOP |=> hold_level_reg == LEVEL_STOPPED)
        else $error("stop request did not mark the hold as stopped");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && operation == OP_STOP |-> !push)
        else $error("stop request produced an event");

endmodule

// ===== rtl/bhe_queue.sv =====
// short queue of per-poll event bundles between front and back
module bhe_queue
    import bhe_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  bundle_t push_bundle,
    output logic    push_ready,
    output logic    head_valid,
    output bundle_t head_bundle,
    input  logic    pop
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    bundle_t             entries [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg,  count_next;

    assign push_ready  = (count_reg != CNT_BITS'(QUEUE_DEPTH));
    assign head_valid  = (count_reg != '0);
    assign head_bundle = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_bundle;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue lost a pushed bundle");

endmodule

// ===== rtl/bhe_back.sv =====
// back end: steps through the events of the head bundle, one beat per cycle while out_ready is high
module bhe_back
    import bhe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  bundle_t    head_bundle,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] event_button,
    output logic [2:0] event_kind,
    output logic [2:0] prior_level,
    output logic       last_event
);

    logic [1:0] idx_reg, idx_next;
    event_t     cur;
    logic       fire;

    assign cur          = head_bundle.events[idx_reg];
    assign out_valid    = head_valid;
    assign event_button = cur.button;
    assign event_kind   = cur.kind;
    assign prior_level  = cur.prior;
    assign last_event   = (idx_reg == head_bundle.count - 2'd1);
    assign fire         = out_valid && out_ready;
    assign pop          = fire && last_event;

    always_comb
    begin
        idx_next = idx_reg;
        if (fire)
        begin
            idx_next = last_event ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> head_bundle.count != 2'd0 && idx_reg < head_bundle.count)
        else $error("beat index outside the head bundle");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && !last_event |=> out_valid && event_button == $past(event_button))
        else $error("bundle cut short before its last beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> idx_reg == 2'd0)
        else $error("beat index left over with no bundle");

endmodule

// ===== rtl/button_hold_event_generator.sv =====
// top level: button hold event generator with long-press levels and auto repeat
// an accepted poll's bundle is registered in the queue; its first event beat shows once it reaches the queue head
// one poll per cycle enters while the queue has room; the output drains one event beat per cycle
// while out_ready is high; a poll causes at most 3 event beats, all through the single output port
// a two-bundle queue between classification and output lets polls enter while beats wait
// reset: asynchronous active low; registers return to defaults, no button active, queue empty
module button_hold_event_generator
    import bhe_pkg::*;
#(
    parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      operation,
    input  logic [1:0]                button,
    input  logic                      pressed,
    input  logic [NOW_BITS-1:0]       now_ms,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                event_button,
    output logic [2:0]                event_kind,
    output logic [2:0]                prior_level,
    output logic                      last_event
);

    logic    push;
    bundle_t push_bundle;
    logic    push_ready;
    logic    head_valid;
    bundle_t head_bundle;
    logic    pop;

    bhe_front #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .TIME_BITS   (TIME_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .button      (button),
        .pressed     (pressed),
        .now_ms      (now_ms),
        .push        (push),
        .push_bundle (push_bundle),
        .push_ready  (push_ready)
    );

    bhe_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .push_ready  (push_ready),
        .head_valid  (head_valid),
        .head_bundle (head_bundle),
        .pop         (pop)
    );

    bhe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_bundle  (head_bundle),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_button (event_button),
        .event_kind   (event_kind),
        .prior_level  (prior_level),
        .last_event   (last_event)
    );

endmodule

// ===== tb/sv/tb_button_hold_event_generator.sv =====
// self-checking testbench for the button hold event generator: hold levels, repeats, stops
module tb_button_hold_event_generator;
    import bhe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] BTN_SELECT = 2'd0;
    localparam logic [1:0] BTN_ALT    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int HOLDOFF_CYCLES = 300;

    typedef struct packed {
        logic [1:0] button;
        logic [2:0] kind;
        logic [2:0] prior;
        logic       last;
    } event_beat_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic                      operation;
    logic [1:0]                button;
    logic                      pressed;
    logic [NOW_BITS-1:0]       now_ms;
    logic                      out_valid;
    logic                      out_ready;
    logic [1:0]                event_button;
    logic [2:0]                event_kind;
    logic [2:0]                prior_level;
    logic                      last_event;

    // predictor copy of the registers and the hold state
    logic [15:0] short_ms     = SHORT_HOLD_RST;
    logic [15:0] long_ms      = LONG_HOLD_RST;
    logic [15:0] verylong_ms  = VERYLONG_HOLD_RST;
    logic [15:0] superlong_ms = SUPERLONG_HOLD_RST;
    logic [15:0] slow_ms      = SLOW_REPEAT_RST;
    logic [15:0] fast_ms      = FAST_REPEAT_RST;
    logic        repeat_on    = REPEAT_ENABLE_RST;
    logic        held_valid   = 1'b0;
    logic [1:0]  held_button  = 2'd0;
    logic [2:0]  held_level   = LEVEL_NONE;
    logic [31:0] pressed_at   = 32'd0;
    logic [31:0] repeated_at  = 32'd0;

    event_beat_t expected_events[$];
    int          mismatch_count = 0;
    bit          sender_idling = 1'b1;
    bit          receiver_idling = 1'b1;
    int          rx_hold = 0;

    button_hold_event_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .button       (button),
        .pressed      (pressed),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_button (event_button),
        .event_kind   (event_kind),
        .prior_level  (prior_level),
        .last_event   (last_event)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic predict_hold_events(input logic op, input logic [1:0] btn,
                                       input logic down, input logic [31:0] now);
        event_beat_t beats[$];
        logic [31:0] held;
        logic [2:0]  lvl;
        logic [15:0] rate;
        if (op == OP_STOP)
        begin
            held_level = LEVEL_STOPPED;
            return;
        end
        if (!held_valid && down)
        begin
            held_valid  = 1'b1;
            held_button = btn;
            held_level  = LEVEL_NONE;
            pressed_at  = now;
            beats.push_back('{btn, KIND_PRESS, LEVEL_NONE, 1'b0});
        end
        if (held_valid && held_button == btn && down)
        begin
            held = now - pressed_at;
            lvl  = LEVEL_NONE;
            if (held >= superlong_ms && held_level < LEVEL_SUPERLONG)
                lvl = LEVEL_SUPERLONG;
            else if (held >= verylong_ms && held_level < LEVEL_VERYLONG)
                lvl = LEVEL_VERYLONG;
            else if (held >= long_ms && held_level < LEVEL_LONG)
                lvl = LEVEL_LONG;
            else if (held >= short_ms && held_level < LEVEL_SHORT)
                lvl = LEVEL_SHORT;
            if (lvl != LEVEL_NONE)
            begin
                beats.push_back('{btn, lvl, held_level, 1'b0});
                held_level = lvl;
                if (lvl == LEVEL_SHORT)
                    repeated_at = now;
            end
            if ((btn == BTN_UP || btn == BTN_DOWN) && repeat_on && held_level >= LEVEL_SHORT)
            begin
                rate = (held_level >= LEVEL_LONG) ? fast_ms : slow_ms;
                if (now - repeated_at >= rate)
                begin
                    repeated_at = now;
                    beats.push_back('{btn, KIND_PRESS, held_level, 1'b0});
                end
            end
        end
        if (held_valid && held_button == btn && !down)
        begin
            held_valid = 1'b0;
            if (held_level != LEVEL_STOPPED)
                beats.push_back('{btn, KIND_RELEASE, held_level, 1'b0});
            held_level = LEVEL_NONE;
        end
        if (beats.size() > 0)
            beats[beats.size() - 1].last = 1'b1;
        foreach (beats[i])
            expected_events.push_back(beats[i]);
    endtask

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_poll(input logic op, input logic [1:0] btn, input logic down,
                             input logic [31:0] now);
        if (sender_idling && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_valid  = 1'b1;
        operation = op;
        button    = btn;
        pressed   = down;
        now_ms    = now;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_hold_events(op, btn, down, now);
        @(negedge clk);
    endtask

    task automatic wait_results_done();
        in_valid = 1'b0;
        while (expected_events.size() != 0)
            @(negedge clk);
    endtask

    task automatic wait_drained();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_SHORT_HOLD:     short_ms = data;
            REG_LONG_HOLD:      long_ms = data;
            REG_VERYLONG_HOLD:  verylong_ms = data;
            REG_SUPERLONG_HOLD: superlong_ms = data;
            REG_SLOW_REPEAT:    slow_ms = data;
            REG_FAST_REPEAT:    fast_ms = data;
            REG_REPEAT_ENABLE:  repeat_on = data[0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [15:0] s, input logic [15:0] l,
                               input logic [15:0] v, input logic [15:0] sl,
                               input logic [15:0] slow, input logic [15:0] fast,
                               input logic [15:0] en_word);
        wait_drained();
        write_reg(REG_SHORT_HOLD, s);
        write_reg(REG_LONG_HOLD, l);
        write_reg(REG_VERYLONG_HOLD, v);
        write_reg(REG_SUPERLONG_HOLD, sl);
        write_reg(REG_SLOW_REPEAT, slow);
        write_reg(REG_FAST_REPEAT, fast);
        write_reg(REG_REPEAT_ENABLE, en_word);
    endtask

    task automatic load_random_config();
        logic [15:0] s;
        logic [15:0] l;
        logic [15:0] v;
        logic [15:0] sl;
        if ($urandom_range(0, 3) == 0)
        begin
            // unordered thresholds
            s  = 16'($urandom);
            l  = 16'($urandom);
            v  = 16'($urandom);
            sl = 16'($urandom);
        end
        else
        begin
            s  = 16'($urandom_range(0, 200));
            l  = 16'(s + $urandom_range(0, 200));
            v  = 16'(l + $urandom_range(0, 200));
            sl = 16'(v + $urandom_range(0, 400));
        end
        load_config(s, l, v, sl, 16'($urandom_range(0, 40)), 16'($urandom_range(0, 15)),
                    16'($urandom_range(0, 65535)));
    endtask

    // press, a few held polls with stops and noise, then usually a release
    task automatic run_hold_sequences(input int count);
        int          sent;
        int          steps;
        int unsigned span;
        logic [1:0]  btn;
        logic [31:0] t;
        sent = 0;
        while (sent < count)
        begin
            btn  = 2'($urandom_range(0, 3));
            t    = $urandom;
            span = superlong_ms / 3 + slow_ms + 4;
            send_poll(OP_POLL, btn, 1'b1, t);
            sent++;
            steps = $urandom_range(1, 8);
            repeat (steps)
            begin
                case ($urandom_range(0, 15))
                    0: send_poll(OP_STOP, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                 $urandom);
                    1: send_poll(OP_POLL, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                 t);
                    2:
                    begin
                        t = t + $urandom;
                        send_poll(OP_POLL, btn, 1'b1, t);
                    end
                    default:
                    begin
                        t = t + $urandom_range(0, span);
                        send_poll(OP_POLL, btn, 1'b1, t);
                    end
                endcase
                sent++;
            end
            if ($urandom_range(0, 7) != 0)
            begin
                send_poll(OP_POLL, btn, 1'b0, t + $urandom_range(0, span));
                sent++;
            end
        end
    endtask

    task automatic test_directed_holds();
        logic [31:0] t;
        t = 32'h0000_1000;
        // stop with nothing active, then a fresh press clears it
        send_poll(OP_STOP, BTN_ALT, 1'b1, 32'd0);
        send_poll(OP_POLL, BTN_SELECT, 1'b0, t);
        send_poll(OP_POLL, BTN_SELECT, 1'b1, t);
        send_poll(OP_POLL, BTN_SELECT, 1'b1, t + 999);
        send_poll(OP_POLL, BTN_ALT, 1'b1, t + 1000);
        send_poll(OP_POLL, BTN_SELECT, 1'b1, t + 1000);
        send_poll(OP_POLL, BTN_SELECT, 1'b1, t + 3000);
        send_poll(OP_POLL, BTN_SELECT, 1'b1, t + 5000);
        send_poll(OP_POLL, BTN_SELECT, 1'b1, t + 15000);
        send_poll(OP_POLL, BTN_SELECT, 1'b1, t + 20000);
        send_poll(OP_POLL, BTN_SELECT, 1'b0, t + 20001);
        // up held across the timestamp wrap, slow then fast repeats, then stopped
        t = 32'hFFFF_FF00;
        send_poll(OP_POLL, BTN_UP, 1'b1, t);
        send_poll(OP_POLL, BTN_UP, 1'b1, t + 1000);
        send_poll(OP_POLL, BTN_UP, 1'b1, t + 1125);
        send_poll(OP_POLL, BTN_UP, 1'b1, t + 3000);
        send_poll(OP_POLL, BTN_UP, 1'b1, t + 3010);
        send_poll(OP_POLL, BTN_UP, 1'b1, t + 3020);
        send_poll(OP_STOP, BTN_DOWN, 1'b0, 32'hFFFF_FFFF);
        send_poll(OP_POLL, BTN_UP, 1'b1, t + 3040);
        send_poll(OP_POLL, BTN_UP, 1'b0, t + 3050);
        // late poll skips straight to the top level
        t = 32'h8000_0000;
        send_poll(OP_POLL, BTN_DOWN, 1'b1, t);
        send_poll(OP_POLL, BTN_DOWN, 1'b1, t + 20000);
        send_poll(OP_POLL, BTN_DOWN, 1'b0, t + 20001);
        send_poll(OP_POLL, BTN_ALT, 1'b1, 32'h5555_AAAA);
        send_poll(OP_POLL, BTN_ALT, 1'b0, 32'h5555_AAAB);
    endtask

    task automatic test_threshold_extremes();
        logic [31:0] t;
        // all zero: three events per up or down press, two for other buttons, a repeat on every held poll
        load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
        t = $urandom;
        send_poll(OP_POLL, BTN_UP, 1'b1, t);
        send_poll(OP_POLL, BTN_UP, 1'b1, t);
        send_poll(OP_STOP, BTN_SELECT, 1'b1, t);
        send_poll(OP_POLL, BTN_UP, 1'b1, t + 1);
        send_poll(OP_POLL, BTN_UP, 1'b0, t + 2);
        send_poll(OP_POLL, BTN_SELECT, 1'b1, t + 3);
        send_poll(OP_POLL, BTN_SELECT, 1'b0, t + 4);
        // all maximum with repeat off; unused index must change nothing
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE);
        write_reg(REG_UNUSED, 16'h5A5A);
        t = $urandom;
        send_poll(OP_POLL, BTN_DOWN, 1'b1, t);
        send_poll(OP_POLL, BTN_DOWN, 1'b1, t + 65534);
        send_poll(OP_POLL, BTN_DOWN, 1'b1, t + 65535);
        send_poll(OP_POLL, BTN_DOWN, 1'b1, t + 70000);
        send_poll(OP_POLL, BTN_DOWN, 1'b0, t + 70001);
    endtask

    task automatic test_output_holdoff();
        logic [31:0] t;
        load_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0001);
        sender_idling = 1'b0;
        rx_hold = HOLDOFF_CYCLES;
        t = $urandom;
        send_poll(OP_POLL, BTN_UP, 1'b1, t);
        repeat (10)
        begin
            t = t + $urandom_range(0, 3);
            send_poll(OP_POLL, BTN_UP, 1'b1, t);
        end
        send_poll(OP_POLL, BTN_UP, 1'b0, t);
        send_poll(OP_POLL, BTN_DOWN, 1'b1, t);
        send_poll(OP_POLL, BTN_DOWN, 1'b1, t + 1);
        send_poll(OP_POLL, BTN_DOWN, 1'b0, t + 2);
        sender_idling = 1'b1;
    endtask

    task automatic test_sender_pause();
        logic [31:0] t;
        load_config(16'd10, 16'd30, 16'd60, 16'd150, 16'd7, 16'd3, 16'h0001);
        t = $urandom;
        send_poll(OP_POLL, BTN_DOWN, 1'b1, t);
        wait_results_done();
        send_poll(OP_POLL, BTN_DOWN, 1'b1, t + 12);
        send_poll(OP_POLL, BTN_DOWN, 1'b1, t + 40);
        wait_results_done();
        send_poll(OP_POLL, BTN_DOWN, 1'b0, t + 41);
    endtask

    task automatic test_random_holds();
        load_config(16'd10, 16'd30, 16'd60, 16'd150, 16'd7, 16'd3, 16'h0001);
        run_hold_sequences(40);
        load_config(SHORT_HOLD_RST, LONG_HOLD_RST, VERYLONG_HOLD_RST, SUPERLONG_HOLD_RST,
                    SLOW_REPEAT_RST, FAST_REPEAT_RST, 16'h0001);
        run_hold_sequences(30);
        repeat (3)
        begin
            load_random_config();
            run_hold_sequences(20);
        end
    endtask

    task automatic test_random_no_idling();
        load_random_config();
        sender_idling   = 1'b0;
        receiver_idling = 1'b0;
        run_hold_sequences(40);
    endtask

    // receiver: long hold-off when asked, else random stall bursts while receiver idling is on
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_ready = 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready = 1'b0;
            end
            else if (receiver_idling && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 18);
                out_ready = 1'b0;
            end
            else
                out_ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_beats
        event_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_events.size() == 0)
                report_mismatch($sformatf("unexpected beat button %0d kind %0d",
                                          event_button, event_kind));
            else
            begin
                want = expected_events.pop_front();
                if (event_button !== want.button)
                    report_mismatch($sformatf("event_button %0d, want %0d",
                                              event_button, want.button));
                if (event_kind !== want.kind)
                    report_mismatch($sformatf("event_kind %0d, want %0d",
                                              event_kind, want.kind));
                if (prior_level !== want.prior)
                    report_mismatch($sformatf("prior_level %0d, want %0d",
                                              prior_level, want.prior));
                if (last_event !== want.last)
                    report_mismatch($sformatf("last_event %0d, want %0d",
                                              last_event, want.last));
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_SHORT_HOLD;
        cfg_data  = '0;
        in_valid  = 1'b0;
        operation = OP_POLL;
        button    = BTN_SELECT;
        pressed   = 1'b0;
        now_ms    = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_holds();
        test_threshold_extremes();
        test_output_holdoff();
        test_sender_pause();
        test_random_holds();
        test_random_no_idling();

        wait_results_done();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
